// ----- rtl/dmm_pkg.sv -----
// Shared types and codes for the three-digit display multiplexer.
package dmm_pkg;

    // Operation codes carried in the input tuser field.
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_BUTTON = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Width of one stored display code.
    localparam int unsigned DIGIT_W = 4;

    // Letter codes shown on the alert screen.
    localparam logic [DIGIT_W-1:0] ALERT_HUND  = 4'hA;
    localparam logic [DIGIT_W-1:0] ALERT_TENS  = 4'hB;
    localparam logic [DIGIT_W-1:0] ALERT_UNITS = 4'hC;

    // Screen modes, advanced cyclically by the button.
    typedef enum logic [3:0] {
        MODE_SPEED = 4'b0001,
        MODE_RPM   = 4'b0010,
        MODE_ODO   = 4'b0100,
        MODE_ALERT = 4'b1000
    } mode_t;

    // Control tag that travels beside the data through every stage.
    typedef struct packed {
        logic  valid;
        logic  tick;
        mode_t mode;
    } tag_t;

    // Three decimal digits of a displayed value.
    typedef struct packed {
        logic [DIGIT_W-1:0] hund;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] units;
    } digits_t;

endpackage

// ----- rtl/dmm_value.sv -----
// Value stages: speed, rpm and odometer quotients by reciprocal multiplication.
module dmm_value
    import dmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  tag_t        in_tag,
    input  logic [15:0] in_rpm,
    input  logic [31:0] in_pulse,
    output tag_t        out_tag,
    output logic [21:0] out_val
);

    localparam logic [17:0] SPD_RECIP  = 18'd254201;    // 2^23 / 33, rounded up
    localparam logic [16:0] RPM_RECIP  = 17'd87382;     // 2^18 / 3, rounded up
    localparam logic [27:0] ODO_RECIP  = 28'd175921861; // 2^39 / 3125, rounded up
    localparam logic [15:0] ODO_DIV    = 16'd50000;
    localparam logic [6:0]  ODO_SCALE  = 7'd97;
    localparam logic [22:0] FRAC_RECIP = 23'd8332237;   // 97 * 2^32 / 50000, rounded up

    tag_t        v1_tag_reg, v2_tag_reg, v3_tag_reg;
    logic [14:0] v1_sr_reg, v2_sr_reg;
    logic [21:0] v3_val_reg;
    logic [15:0] v1_a_reg;
    logic [30:0] v1_h_reg;
    logic [15:0] v2_b_reg;
    logic [22:0] v2_a97_reg;

    logic [34:0] spd_prod;
    logic [32:0] rpm_prod;
    logic [54:0] odo_prod;
    logic [14:0] v1_sr_next;
    logic [31:0] a_times_div;
    logic [31:0] b_diff;
    logic [22:0] a97_next;
    logic [38:0] frac_prod;
    logic [22:0] odo_sum;
    logic [21:0] v3_val_next;

    // First stage: the three quotients, each one multiplier wide.
    assign spd_prod = 35'({in_rpm, 1'b0}) * 35'(SPD_RECIP);
    assign rpm_prod = 33'(in_rpm) * 33'(RPM_RECIP);
    assign odo_prod = 55'(in_pulse[31:5]) * 55'(ODO_RECIP);
    assign v1_sr_next = (in_tag.mode == MODE_SPEED) ? 15'(spd_prod[34:23]) : rpm_prod[32:18];

    // Second stage: split half the pulse count into 50000 * a + b.
    assign a_times_div = 32'(v1_a_reg) * 32'(ODO_DIV);
    assign b_diff      = {1'b0, v1_h_reg} - a_times_div;
    assign a97_next    = 23'(v1_a_reg) * 23'(ODO_SCALE);

    // Third stage: kilometers are 97 * a plus the fraction from b. The full
    // kilometer count needs 22 bits, so it is passed on whole.
    assign frac_prod   = 39'(v2_b_reg) * 39'(FRAC_RECIP);
    assign odo_sum     = v2_a97_reg + 23'(frac_prod[38:32]);
    assign v3_val_next = (v2_tag_reg.mode == MODE_ODO) ? odo_sum[21:0] : 22'(v2_sr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_tag_reg <= '0;
            v2_tag_reg <= '0;
            v3_tag_reg <= '0;
        end
        else if (adv)
        begin
            v1_tag_reg <= in_tag;
            v2_tag_reg <= v1_tag_reg;
            v3_tag_reg <= v2_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v1_sr_reg  <= v1_sr_next;
            v1_a_reg   <= odo_prod[54:39];
            v1_h_reg   <= in_pulse[31:1];
            v2_sr_reg  <= v1_sr_reg;
            v2_b_reg   <= b_diff[15:0];
            v2_a97_reg <= a97_next;
            v3_val_reg <= v3_val_next;
        end
    end

    assign out_tag = v3_tag_reg;
    assign out_val = v3_val_reg;

endmodule

// ----- rtl/dmm_split.sv -----
// Digit stages: value modulo 1000 split into hundreds, tens and units.
module dmm_split
    import dmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  tag_t        in_tag,
    input  logic [21:0] in_val,
    output tag_t        out_tag,
    output digits_t     out_digits
);

    localparam logic [22:0] K_RECIP   = 23'd4294968; // 2^32 / 1000, rounded up
    localparam logic [9:0]  K_DIV     = 10'd1000;
    localparam logic [5:0]  H_RECIP   = 6'd41;     // 2^12 / 100, exact below 1000
    localparam logic [6:0]  H_DIV     = 7'd100;
    localparam logic [7:0]  T_RECIP   = 8'd205;    // 2^11 / 10, exact below 100
    localparam logic [3:0]  T_DIV     = 4'd10;

    tag_t               d1_tag_reg, d2_tag_reg, d3_tag_reg, d4_tag_reg, d5_tag_reg;
    logic [21:0]        d1_val_reg;
    logic [12:0]        d1_q_reg;
    logic [9:0]         d2_r_reg, d3_r_reg;
    logic [DIGIT_W-1:0] d3_h_reg, d4_h_reg, d5_h_reg;
    logic [6:0]         d4_rem_reg, d5_rem_reg;
    logic [DIGIT_W-1:0] d5_t_reg;

    logic [44:0] q_prod;
    logic [21:0] q_times_k;
    logic [21:0] r_diff;
    logic [15:0] h_prod;
    logic [9:0]  h_times_div;
    logic [9:0]  rem_diff;
    logic [14:0] t_prod;
    logic [6:0]  t_times_div;
    logic [6:0]  u_diff;

    assign q_prod      = 45'(in_val) * 45'(K_RECIP);
    assign q_times_k   = 22'(d1_q_reg) * 22'(K_DIV);
    assign r_diff      = d1_val_reg - q_times_k;
    assign h_prod      = 16'(d2_r_reg) * 16'(H_RECIP);
    assign h_times_div = 10'(d3_h_reg) * 10'(H_DIV);
    assign rem_diff    = d3_r_reg - h_times_div;
    assign t_prod      = 15'(d4_rem_reg) * 15'(T_RECIP);
    assign t_times_div = 7'(d5_t_reg) * 7'(T_DIV);
    assign u_diff      = d5_rem_reg - t_times_div;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_tag_reg <= '0;
            d2_tag_reg <= '0;
            d3_tag_reg <= '0;
            d4_tag_reg <= '0;
            d5_tag_reg <= '0;
        end
        else if (adv)
        begin
            d1_tag_reg <= in_tag;
            d2_tag_reg <= d1_tag_reg;
            d3_tag_reg <= d2_tag_reg;
            d4_tag_reg <= d3_tag_reg;
            d5_tag_reg <= d4_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_val_reg <= in_val;
            d1_q_reg   <= q_prod[44:32];
            d2_r_reg   <= r_diff[9:0];
            d3_r_reg   <= d2_r_reg;
            d3_h_reg   <= h_prod[15:12];
            d4_h_reg   <= d3_h_reg;
            d4_rem_reg <= rem_diff[6:0];
            d5_h_reg   <= d4_h_reg;
            d5_rem_reg <= d4_rem_reg;
            d5_t_reg   <= t_prod[14:11];
        end
    end

    assign out_tag          = d5_tag_reg;
    assign out_digits.hund  = d5_h_reg;
    assign out_digits.tens  = d5_t_reg;
    assign out_digits.units = u_diff[3:0];

endmodule

// ----- rtl/three_digit_display_mux_with_modes.sv -----
// Top level of the three-digit multiplexed display driver with screen modes.
//
// This block drives a three-digit multiplexed display. Each input beat carries an
// operation in s_tuser: an update recomputes the three stored digits from the rpm and
// pulse count in s_tdata for the current screen, a button press first advances the
// screen (speed, rpm, odometer, alert, back to speed) and then recomputes, and a scan
// tick produces one output beat with the one-hot enable and the code of the next
// digit (units, tens, hundreds, in turn). Speed is rpm * 120 / 1980, the rpm screen
// shows rpm / 3 and the odometer shows half the pulse count times 194 / 100000 km;
// every value is shown modulo 1000, and the alert screen shows the codes A, B and C.
// The block takes one beat per clock cycle unless the output stalls. Every beat
// goes through the same ten-register path in order (input register, three value
// stages, five digit stages, output register), so a tick beat always sees the
// digits of every update accepted before it. The whole path moves together:
// s_tready drops only while a finished output beat waits in the output register
// and m_tready is low. Updates and button presses produce no output beat, and
// operation code 3 is ignored.
module three_digit_display_mux_with_modes
    import dmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // [15:0] rpm, [47:16] pulse_count
    input  logic [1:0]  s_tuser,  // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // [2:0] digit_enable, [6:3] digit_code, [7] zero
);

    // The path advances whenever the output register is free or being emptied.
    logic adv;
    logic accept;

    mode_t mode_reg, mode_next;
    tag_t  in_tag_next;
    tag_t  s1_tag_reg;
    logic [15:0] s1_rpm_reg;
    logic [31:0] s1_pulse_reg;

    tag_t        val_tag;
    logic [21:0] val_val;
    tag_t        fin_tag;
    digits_t     fin_digits;

    logic [DIGIT_W-1:0] digit_store_reg [3];
    logic [1:0]         scan_reg, scan_next;
    logic [2:0]         enable_next;
    logic [DIGIT_W-1:0] code_next;
    logic               m_tvalid_reg;
    logic [7:0]         m_tdata_reg;

    logic fin_update;
    logic fin_tick;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    // Next screen in the cyclic order.
    always_comb
    begin
        unique case (mode_reg)
            MODE_SPEED: mode_next = MODE_RPM;
            MODE_RPM:   mode_next = MODE_ODO;
            MODE_ODO:   mode_next = MODE_ALERT;
            MODE_ALERT: mode_next = MODE_SPEED;
            default:    mode_next = MODE_SPEED;
        endcase
    end

    // The beat carries the screen it must be computed for, after any button press.
    always_comb
    begin
        in_tag_next = '0;
        unique case (s_tuser)
            OP_UPDATE:
            begin
                in_tag_next.valid = accept;
                in_tag_next.mode  = mode_reg;
            end
            OP_BUTTON:
            begin
                in_tag_next.valid = accept;
                in_tag_next.mode  = mode_next;
            end
            OP_TICK:
            begin
                in_tag_next.valid = accept;
                in_tag_next.tick  = 1'b1;
                in_tag_next.mode  = mode_reg;
            end
            OP_NONE:
            begin
                in_tag_next.valid = 1'b0;
                in_tag_next.mode  = mode_reg;
            end
            default:
            begin
                in_tag_next.valid = 1'b0;
                in_tag_next.mode  = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_SPEED;
            s1_tag_reg <= '0;
        end
        else if (adv)
        begin
            if (accept && s_tuser == OP_BUTTON)
            begin
                mode_reg <= mode_next;
            end
            s1_tag_reg <= in_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_rpm_reg   <= s_tdata[15:0];
            s1_pulse_reg <= s_tdata[47:16];
        end
    end

    dmm_value u_value (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_tag   (s1_tag_reg),
        .in_rpm   (s1_rpm_reg),
        .in_pulse (s1_pulse_reg),
        .out_tag  (val_tag),
        .out_val  (val_val)
    );

    dmm_split u_split (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_tag     (val_tag),
        .in_val     (val_val),
        .out_tag    (fin_tag),
        .out_digits (fin_digits)
    );

    assign fin_update = fin_tag.valid && !fin_tag.tick;
    assign fin_tick   = fin_tag.valid && fin_tag.tick;

    // Scan position selects the digit; a position past hundreds restarts at units.
    always_comb
    begin
        unique case (scan_reg)
            2'd0:
            begin
                enable_next = 3'b001;
                code_next   = digit_store_reg[0];
                scan_next   = 2'd1;
            end
            2'd1:
            begin
                enable_next = 3'b010;
                code_next   = digit_store_reg[1];
                scan_next   = 2'd2;
            end
            2'd2:
            begin
                enable_next = 3'b100;
                code_next   = digit_store_reg[2];
                scan_next   = 2'd0;
            end
            default:
            begin
                enable_next = 3'b001;
                code_next   = digit_store_reg[0];
                scan_next   = 2'd1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_store_reg[0] <= '0;
            digit_store_reg[1] <= '0;
            digit_store_reg[2] <= '0;
            scan_reg           <= 2'd0;
            m_tvalid_reg       <= 1'b0;
        end
        else if (adv)
        begin
            if (fin_update)
            begin
                if (fin_tag.mode == MODE_ALERT)
                begin
                    digit_store_reg[2] <= ALERT_HUND;
                    digit_store_reg[1] <= ALERT_TENS;
                    digit_store_reg[0] <= ALERT_UNITS;
                end
                else
                begin
                    digit_store_reg[2] <= fin_digits.hund;
                    digit_store_reg[1] <= fin_digits.tens;
                    digit_store_reg[0] <= fin_digits.units;
                end
            end
            if (fin_tick)
            begin
                scan_reg <= scan_next;
            end
            m_tvalid_reg <= fin_tick;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && fin_tick)
        begin
            m_tdata_reg <= {1'b0, code_next, enable_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A waiting output beat must hold back the input side.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output beat is stalled");

    // A tick reaching the end of the path always becomes an output beat.
    a_tick_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && fin_tick) |=> (m_tvalid && $onehot(m_tdata[2:0])))
        else $error("tick did not produce a one-hot output beat");

    // The scan index never leaves the three digit positions.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg != 2'd3)
        else $error("scan index out of range");

    // Stored codes are decimal digits or alert letters only.
    a_store_codes: assert property (@(posedge clk) disable iff (!rst_n)
        (digit_store_reg[0] <= ALERT_UNITS) && (digit_store_reg[1] <= ALERT_UNITS)
        && (digit_store_reg[2] <= ALERT_UNITS))
        else $error("digit store holds an invalid code");

    // Ticks do not disturb the stored digits.
    a_tick_keeps_store: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && fin_tick) |=> $stable(digit_store_reg[0]) && $stable(digit_store_reg[1])
        && $stable(digit_store_reg[2]))
        else $error("digit store changed on a tick");

endmodule

// ----- verif/three_digit_display_mux_with_modes_test.sv -----
// Self-checking testbench for the three-digit display multiplexer with screen modes.
module three_digit_display_mux_with_modes_test
    import dmm_pkg::*;
();

    // Cycles without any accepted beat on either side before the run is declared hung.
    // The slowest legal stretch is a drain plus the trip through the register path under
    // random stalls, which stays far below this.
    localparam int unsigned WATCHDOG_LIMIT = 1000;

    // Cycles allowed after the last scan beat so that any stray output can still show up.
    localparam int unsigned SETTLE_CYCLES = 20;

    // One expected scan beat on the master side.
    typedef struct {
        logic [2:0]         enable;
        logic [DIGIT_W-1:0] code;
    } scan_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;  // [15:0] rpm, [47:16] pulse_count
    logic [1:0]  s_tuser = OP_UPDATE;  // [1:0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;  // [2:0] digit_enable, [6:3] digit_code, [7] zero

    // Our own view of the display state, kept in step with every accepted input beat.
    mode_t       shown_mode = MODE_SPEED;
    digits_t     shown_digits = '0;
    int unsigned scan_slot = 0;

    // Scan beats that the block still owes us, oldest first.
    scan_beat_t  scan_expect_q[$];
    scan_beat_t  want_beat;

    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;

    // When set, neither side inserts idle cycles.
    bit          steady = 1'b0;

    three_digit_display_mux_with_modes u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // The button walks the screens in a fixed ring.
    function automatic mode_t next_screen(mode_t mode);
        case (mode)
            MODE_SPEED: return MODE_RPM;
            MODE_RPM:   return MODE_ODO;
            MODE_ODO:   return MODE_ALERT;
            default:    return MODE_SPEED;
        endcase
    endfunction

    // Digits that a screen shows for the given readings. The arithmetic is done in
    // 64 bits so that the speed and odometer products never lose their upper bits.
    function automatic digits_t screen_digits(mode_t mode, logic [15:0] rpm,
                                              logic [31:0] pulses);
        logic [63:0] value;
        int unsigned rem;
        digits_t     digits;
        case (mode)
            MODE_SPEED: value = (64'(rpm) * 64'd120) / 64'd1980;
            MODE_RPM:   value = 64'(rpm) / 64'd3;
            MODE_ODO:   value = (((64'(pulses) / 64'd2) * 64'd194) / 64'd100) / 64'd1000;
            default:    value = '0;
        endcase
        if (mode == MODE_ALERT)
        begin
            digits.hund  = ALERT_HUND;
            digits.tens  = ALERT_TENS;
            digits.units = ALERT_UNITS;
        end
        else
        begin
            // Only the last three decimal places ever reach the display.
            rem          = int'(value % 64'd1000);
            digits.hund  = DIGIT_W'(rem / 100);
            digits.tens  = DIGIT_W'((rem / 10) % 10);
            digits.units = DIGIT_W'(rem % 10);
        end
        return digits;
    endfunction

    // Apply one accepted input beat to our copy of the display state and queue the
    // scan beat that a tick produces. Operation code 3 leaves everything alone.
    task automatic track_beat(logic [1:0] op, logic [15:0] rpm, logic [31:0] pulses);
        scan_beat_t beat;
        case (op)
            OP_UPDATE:
                shown_digits = screen_digits(shown_mode, rpm, pulses);
            OP_BUTTON:
            begin
                shown_mode   = next_screen(shown_mode);
                shown_digits = screen_digits(shown_mode, rpm, pulses);
            end
            OP_TICK:
            begin
                beat.enable = 3'b001 << scan_slot;
                case (scan_slot)
                    0:       beat.code = shown_digits.units;
                    1:       beat.code = shown_digits.tens;
                    default: beat.code = shown_digits.hund;
                endcase
                scan_expect_q.push_back(beat);
                scan_slot = (scan_slot >= 2) ? 0 : scan_slot + 1;
            end
            default:
                ;
        endcase
    endtask

    // Offer one beat on the slave side, possibly after a short random gap, and wait
    // until the block takes it. Valid stays high afterwards so that the next call can
    // follow back to back; anything that pauses the sender lowers it first.
    task automatic send_beat(logic [1:0] op, logic [15:0] rpm, logic [31:0] pulses);
        if (!steady && $urandom_range(99) < 33)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(2)) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pulses, rpm};
        do
            @(posedge clk);
        while (!s_tready);
        track_beat(op, rpm, pulses);
    endtask

    // Stop sending and hold off until every owed scan beat has come out.
    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (scan_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // One full scan cycle: units, tens and hundreds. The data fields of a tick are
    // don't-care, so they carry random bits.
    task automatic scan_all_digits();
        repeat (3) send_beat(OP_TICK, 16'($urandom), $urandom);
    endtask

    // Right after reset the speed screen holds three zero digits.
    task automatic test_reset_state();
        scan_all_digits();
    endtask

    // Walk the whole ring of screens with the extreme readings, scanning each one.
    task automatic test_screen_modes();
        send_beat(OP_UPDATE, 16'hFFFF, 32'h0000_0000);
        scan_all_digits();
        send_beat(OP_BUTTON, 16'hFFFF, 32'h0000_0000);
        scan_all_digits();
        send_beat(OP_BUTTON, 16'h0000, 32'hFFFF_FFFF);
        scan_all_digits();
        send_beat(OP_BUTTON, 16'hFFFF, 32'hFFFF_FFFF);
        scan_all_digits();
        // Back to the speed screen with zero readings.
        send_beat(OP_BUTTON, 16'h0000, 32'h0000_0000);
        send_beat(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    // The unused operation code must change neither the screen, the digits nor the
    // scan position.
    task automatic test_ignored_op();
        send_beat(OP_NONE, 16'hFFFF, 32'hFFFF_FFFF);
        send_beat(OP_TICK, 16'h0000, 32'h0000_0000);
    endtask

    // Long random mix. Ticks dominate so that plenty of digits get checked, buttons
    // come often enough to visit every screen many times, and readings mix the full
    // range, small values and the ends of the range. A stretch in the middle runs
    // with no idling on either side, and later the sender drains the block once.
    task automatic test_random_mix();
        logic [1:0]  op;
        logic [15:0] rpm;
        logic [31:0] pulses;
        int unsigned pick;
        for (int n = 0; n < 1577; n++)
        begin
            steady = (n >= 700 && n < 950);
            if (n == 1300)
                wait_for_results();
            pick = $urandom_range(99);
            if (pick < 45)
                op = OP_TICK;
            else if (pick < 70)
                op = OP_UPDATE;
            else if (pick < 85)
                op = OP_BUTTON;
            else
                op = OP_NONE;
            case ($urandom_range(3))
                0:       rpm = 16'($urandom);
                1:       rpm = 16'($urandom_range(2000));
                2:       rpm = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                default: rpm = 16'($urandom_range(65535, 60000));
            endcase
            case ($urandom_range(3))
                0:       pulses = $urandom;
                1:       pulses = $urandom_range(2_000_000);
                2:       pulses = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                default: pulses = $urandom_range(32'hFFFF_FFFF, 32'hF000_0000);
            endcase
            send_beat(op, rpm, pulses);
        end
        steady = 1'b0;
    endtask

    // The receiver stalls at random, except during the steady stretch.
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= steady || ($urandom_range(99) >= 33);
    end

    // Compare every scan beat that leaves the block with the oldest one we expect.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (scan_expect_q.size() == 0)
            begin
                $error("unexpected scan beat: digit_enable %0d, digit_code %0d",
                       m_tdata[2:0], m_tdata[6:3]);
                error_count++;
            end
            else
            begin
                want_beat = scan_expect_q.pop_front();
                if (m_tdata[2:0] !== want_beat.enable)
                begin
                    $error("digit_enable: expected %0d, got %0d",
                           want_beat.enable, m_tdata[2:0]);
                    error_count++;
                end
                if (m_tdata[6:3] !== want_beat.code)
                begin
                    $error("digit_code: expected %0d, got %0d",
                           want_beat.code, m_tdata[6:3]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a run in which nothing moves for too long has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_screen_modes();
        test_ignored_op();
        test_random_mix();

        // Let every owed scan beat arrive, then give a stray beat time to appear.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
